// File: sv/gtm_pkg.sv
// shared types and constants for the gesture template matcher
package gtm_pkg;

  // default capture length in samples
  localparam int unsigned SAMPLES_DEF = 30;

  // field widths
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned ENTRY_W = 3 * RATE_W;
  localparam int unsigned ACC_W   = 39;
  localparam int unsigned IDX_W   = 7;

  // error sum ceiling and reset threshold (0.05 mean square over 90 axis samples)
  localparam logic [ACC_W-1:0] ACC_MAX       = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] THRESHOLD_RST = 39'd4831838208;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_RECORD = 2'd1,
    REQ_VERIFY = 2'd2
  } req_e;

  // capture mode, reported as phase
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_VERIFY = 2'd2
  } mode_e;

endpackage

// File: sv/gesture_template_matcher_top.sv
// gesture template matcher: record a template, verify a capture by sum of squared differences
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | req_type, x_rate, y_rate, z_rate
//  out     | output    | out_valid_o / out_stall_i | phase, sample_index, flags, error_sum
//  cfg     | input     | cfg_we_i                  | match_threshold (cfg_wdata_i)
//
// one item per cycle while the output does not stall; a transfer is held in the input register,
// then passes through three 17x17 squarers and the accumulator add into the result register.
// the template store is a memory whose entry at the next capture position is read ahead into a register.
// reset clears all control state and the per-entry valid bits: no clearing pass is needed.
// an output stall holds the result register and backs up into the input register only.
module gesture_template_matcher_top #(
  parameter int unsigned SAMPLES = gtm_pkg::SAMPLES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [gtm_pkg::ACC_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic signed [gtm_pkg::RATE_W-1:0] x_rate_i,
  input  logic signed [gtm_pkg::RATE_W-1:0] y_rate_i,
  input  logic signed [gtm_pkg::RATE_W-1:0] z_rate_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  phase_o,
  output logic [gtm_pkg::IDX_W-1:0]   sample_index_o,
  output logic                        template_stored_o,
  output logic                        verify_done_o,
  output logic                        unlocked_o,
  output logic [gtm_pkg::ACC_W-1:0]   error_sum_o
);

  localparam int unsigned CNT_W  = $clog2(SAMPLES + 1);
  localparam int unsigned ADDR_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned RW     = gtm_pkg::RATE_W;
  localparam int unsigned EW     = gtm_pkg::ENTRY_W;
  localparam int unsigned AW     = gtm_pkg::ACC_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES);

  // input register
  logic                 in_vld_q;
  logic [1:0]           req_q;
  logic [RW-1:0]        x_q, y_q, z_q;

  // block state
  gtm_pkg::mode_e       mode_q, mode_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 tdone_q, tdone_d;
  logic                 vdone_q, vdone_d;
  logic                 unlock_q, unlock_d;
  logic [AW-1:0]        acc_q, acc_d;
  logic [AW-1:0]        thr_q;

  // template store, its valid bits and the prefetched entry
  logic [EW-1:0]        tmpl_mem_q [SAMPLES];
  logic [SAMPLES-1:0]   ent_vld_q;
  logic [EW-1:0]        rd_data_q;
  logic                 rd_vld_q;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_ok;

  // result register
  logic                 out_vld_q;
  logic [1:0]           phase_q;
  logic [CNT_W-1:0]     idx_q;
  logic                 stored_q, vdone_out_q, unlocked_q;
  logic [AW-1:0]        esum_q;

  // datapath
  logic                 fire;
  logic                 in_take;
  logic                 cnt_below;
  logic [EW-1:0]        entry;
  logic signed [RW:0]   dx, dy, dz;
  logic signed [2*RW+1:0] px, py, pz;
  logic [2*RW+1:0]      sq_sum;
  logic [AW:0]          acc_sum;

  // handshake
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= req_type_i;
      x_q   <= x_rate_i;
      y_q   <= y_rate_i;
      z_q   <= z_rate_i;
    end
  end

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= gtm_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // squared differences against the prefetched template entry
  assign cnt_below = (cnt_q < CNT_LAST);
  assign entry     = rd_vld_q ? rd_data_q : '0;
  assign dx        = {entry[RW-1], entry[RW-1:0]}         - {x_q[RW-1], x_q};
  assign dy        = {entry[2*RW-1], entry[2*RW-1:RW]}    - {y_q[RW-1], y_q};
  assign dz        = {entry[3*RW-1], entry[3*RW-1:2*RW]}  - {z_q[RW-1], z_q};
  assign px        = dx * dx;
  assign py        = dy * dy;
  assign pz        = dz * dz;
  assign sq_sum    = {2'b00, px[2*RW-1:0]} + {2'b00, py[2*RW-1:0]}
                   + {2'b00, pz[2*RW-1:0]};
  assign acc_sum   = {1'b0, acc_q} + (AW + 1)'(sq_sum);

  // next state for one item
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    tdone_d  = tdone_q;
    vdone_d  = vdone_q;
    unlock_d = unlock_q;
    acc_d    = acc_q;
    wr_en    = 1'b0;
    wr_addr  = cnt_q[ADDR_W-1:0];
    if (fire) begin
      if (req_q == gtm_pkg::REQ_SAMPLE) begin
        unique case (mode_q)
          gtm_pkg::MODE_RECORD: begin
            if (cnt_below) begin
              wr_en = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end else begin
              mode_d  = gtm_pkg::MODE_IDLE;
              cnt_d   = '0;
              tdone_d = 1'b1;
            end
          end
          gtm_pkg::MODE_VERIFY: begin
            if (cnt_below) begin
              acc_d = acc_sum[AW] ? gtm_pkg::ACC_MAX : acc_sum[AW-1:0];
              cnt_d = cnt_q + 1'b1;
            end else begin
              mode_d   = gtm_pkg::MODE_IDLE;
              cnt_d    = '0;
              vdone_d  = 1'b1;
              unlock_d = (acc_q < thr_q);
            end
          end
          default: begin
            // samples outside a capture are dropped
          end
        endcase
      end else if (mode_q == gtm_pkg::MODE_IDLE) begin
        priority if (req_q == gtm_pkg::REQ_RECORD && !tdone_q) begin
          mode_d = gtm_pkg::MODE_RECORD;
          cnt_d  = '0;
        end else if (req_q == gtm_pkg::REQ_VERIFY && !vdone_q) begin
          mode_d = gtm_pkg::MODE_VERIFY;
          cnt_d  = '0;
          acc_d  = '0;
        end else begin
          // repeated start or unused code
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= gtm_pkg::MODE_IDLE;
      cnt_q    <= '0;
      tdone_q  <= 1'b0;
      vdone_q  <= 1'b0;
      unlock_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      tdone_q  <= tdone_d;
      vdone_q  <= vdone_d;
      unlock_q <= unlock_d;
      acc_q    <= acc_d;
    end
  end

  // template store write, entry at the next position read ahead into a register
  assign rd_ok   = (cnt_d < CNT_LAST);
  assign rd_addr = cnt_d[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tmpl_mem_q[wr_addr] <= {z_q, y_q, x_q};
    end
    if (rd_ok) begin
      rd_data_q <= tmpl_mem_q[rd_addr];
    end
  end

  // valid bits stand in for the all-zero reset of the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= rd_ok && ent_vld_q[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      phase_q     <= mode_d;
      idx_q       <= cnt_d;
      stored_q    <= tdone_d;
      vdone_out_q <= vdone_d;
      unlocked_q  <= unlock_d;
      esum_q      <= acc_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign phase_o           = phase_q;
  assign sample_index_o    = gtm_pkg::IDX_W'(idx_q);
  assign template_stored_o = stored_q;
  assign verify_done_o     = vdone_out_q;
  assign unlocked_o        = unlocked_q;
  assign error_sum_o       = esum_q;

  // capture position never runs past the end of the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LAST)
    else $error("capture position beyond store depth");

  // the position is parked at zero outside a capture
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == gtm_pkg::MODE_IDLE) |-> (cnt_q == '0))
    else $error("capture position not cleared while idle");

  // an unlock is only ever reported with a judged verify
  a_unlock_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && unlocked_q) |-> vdone_out_q)
    else $error("unlock reported without completed verify");

  // the error sum never falls while a verify sample is accumulated
  a_acc_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && req_q == gtm_pkg::REQ_SAMPLE && mode_q == gtm_pkg::MODE_VERIFY && cnt_below)
    |=> (acc_q >= $past(acc_q)))
    else $error("error sum decreased during verify");

endmodule
